// File: hdl/line_position_kalman_filter_unit_macros.svh
// Assertion macros used by the line position filter controller
`ifndef LINE_POSITION_KALMAN_FILTER_UNIT_MACROS_SVH
`define LINE_POSITION_KALMAN_FILTER_UNIT_MACROS_SVH
// same-cycle implication, clocked on clk_i, off during reset
`define LPKF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LPKF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/lpkf_pkg.sv
// Package: types, constants and codes of the line position filter
`timescale 1ns / 1ps
package lpkf_pkg;

  localparam int DIV_W = 50;
  localparam int MAG_W = DIV_W - 1;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 18;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  localparam logic [9:0]  RST_SENSOR_OFFSET = 10'd100;
  localparam logic [7:0]  RST_HALF_WIDTH    = 8'd200;
  localparam logic [20:0] RST_INIT_VAR      = 21'd10000;
  localparam logic [15:0] RST_PROC_NOISE    = 16'd100;
  localparam logic [7:0]  RST_NOISE_LEFT    = 8'd5;
  localparam logic [7:0]  RST_NOISE_RIGHT   = 8'd5;
  localparam logic [8:0]  RST_NOISE_CROSS   = 9'd0;
  localparam logic [7:0]  RST_DRIVE_DIV     = 8'd10;
  localparam logic [7:0]  PEAK_BRIGHTNESS   = 8'd255;

  typedef enum logic [2:0] {
    CFG_SENSOR_OFFSET = 3'd0,
    CFG_HALF_WIDTH    = 3'd1,
    CFG_INIT_VAR      = 3'd2,
    CFG_PROC_NOISE    = 3'd3,
    CFG_NOISE_LEFT    = 3'd4,
    CFG_NOISE_RIGHT   = 3'd5,
    CFG_NOISE_CROSS   = 3'd6,
    CFG_DRIVE_DIV     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        light_left;
    logic [7:0]        light_right;
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic signed [31:0] variance_out;
    logic               update_skipped;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_INIT, OP_PMUL, OP_PDIV, OP_PFIN, OP_SLOPE,
    OP_C1, OP_C2, OP_DET, OP_SKIP, OP_K1, OP_K2, OP_N1, OP_N2, OP_XDIV,
    OP_XFIN, OP_PC, OP_CDIV, OP_CFIN
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_PDIV, ST_PWAIT, ST_PFIN, ST_SLOPE, ST_C1,
    ST_C2, ST_DET, ST_K1, ST_K2, ST_N1, ST_N2, ST_XDIV, ST_XWAIT, ST_XFIN,
    ST_PC, ST_CDIV, ST_CWAIT, ST_CFIN, ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic req_init;
    logic det_zero;
    logic div_done;
  } dp_sts_t;

endpackage

// File: hdl/lpkf_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module lpkf_div
  import lpkf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W-1:0] num_i,
  input  logic signed [DIV_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [DIV_W-1:0] quot_o,
  output logic signed [DIV_W-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W:0]   rem_q, rem_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [MAG_W-1:0] den_q, den_d;
  logic             qneg_q, qneg_d;
  logic             rneg_q, rneg_d;
  logic [DIV_W-1:0] num_abs, den_abs;
  logic [MAG_W:0]   rem_sh;
  logic [MAG_W:0]   rem_sub;

  always_comb begin
    num_abs = num_i[DIV_W-1] ? DIV_W'(-num_i) : DIV_W'(num_i);
    den_abs = den_i[DIV_W-1] ? DIV_W'(-den_i) : DIV_W'(den_i);
    rem_sh  = {rem_q[MAG_W-1:0], quo_q[MAG_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    qneg_d  = qneg_q;
    rneg_d  = rneg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_abs[MAG_W-1:0];
      den_d  = den_abs[MAG_W-1:0];
      qneg_d = num_i[DIV_W-1] ^ den_i[DIV_W-1];
      rneg_d = num_i[DIV_W-1];
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sub;
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MAG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
  assign rem_o  = rneg_q ? -signed'(rem_q) : signed'(rem_q);

endmodule

// File: hdl/lpkf_datapath.sv
// Datapath: configuration, filter state, shared multiplier and divider
`timescale 1ns / 1ps
module lpkf_datapath
  import lpkf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  in_word_t   in_word_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  output out_word_t  out_word_o
);

  logic [9:0]  soff_q;
  logic [7:0]  shw_q;
  logic [20:0] ivar_q;
  logic [15:0] pn_q;
  logic [7:0]  rl_q, rr_q;
  logic signed [8:0] rc_q;
  logic [7:0]  ddiv_q;

  logic signed [31:0] x_q, p_q;
  in_word_t           item_q;
  logic signed [DIV_W-1:0] acc_q, det_q;
  logic signed [17:0] c_q;
  logic signed [MUL_A_W-1:0] k1_q, k2_q;
  logic signed [9:0]  y1_q, y2_q;
  logic signed [11:0] f_q;
  logic signed [10:0] g1_q, g2_q;
  logic               skip_q;
  out_word_t          out_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIV_W-1:0]   prod_t;

  logic [7:0] div_eff;
  logic                    div_start;
  logic signed [DIV_W-1:0] div_num, div_den, div_quot, div_rem;
  logic                    div_done;

  logic signed [33:0] t1, t2;
  logic [7:0]         pv1, pv2;
  logic signed [1:0]  hs1, hs2;
  logic signed [11:0] f_c;
  logic signed [10:0] g1_c, g2_c;
  logic signed [16:0] drive_diff;
  logic signed [DIV_W:0] dq;
  logic                  r_pos, det_pos;

  function automatic logic [7:0] prof_val(input logic signed [33:0] t,
                                          input logic [7:0] hw);
    logic signed [33:0] hws;
    logic [7:0]         v;
    hws = signed'({26'd0, hw});
    if (t < -hws)      v = 8'd0;
    else if (t < 0)    v = 8'(34'sd255 + t);
    else if (t <= hws) v = 8'(34'sd255 - t);
    else               v = 8'd0;
    return v;
  endfunction

  function automatic logic signed [1:0] prof_slope(input logic signed [33:0] t,
                                                  input logic [7:0] hw);
    logic signed [33:0] hws;
    logic signed [1:0]  s;
    hws = signed'({26'd0, hw});
    if (t < -hws)      s = 2'sd0;
    else if (t < 0)    s = 2'sd1;
    else if (t <= hws) s = -2'sd1;
    else               s = 2'sd0;
    return s;
  endfunction

  function automatic logic signed [10:0] sel_sign(input logic signed [1:0] h,
                                                  input logic signed [10:0] v);
    logic signed [10:0] r;
    if (h == 2'sd1)       r = v;
    else if (h == -2'sd1) r = -v;
    else                  r = '0;
    return r;
  endfunction

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soff_q <= RST_SENSOR_OFFSET;
      shw_q  <= RST_HALF_WIDTH;
      ivar_q <= RST_INIT_VAR;
      pn_q   <= RST_PROC_NOISE;
      rl_q   <= RST_NOISE_LEFT;
      rr_q   <= RST_NOISE_RIGHT;
      rc_q   <= signed'(RST_NOISE_CROSS);
      ddiv_q <= RST_DRIVE_DIV;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SENSOR_OFFSET: soff_q <= cfg_data_i[9:0];
        CFG_HALF_WIDTH:    shw_q  <= cfg_data_i[7:0];
        CFG_INIT_VAR:      ivar_q <= cfg_data_i[20:0];
        CFG_PROC_NOISE:    pn_q   <= cfg_data_i[15:0];
        CFG_NOISE_LEFT:    rl_q   <= cfg_data_i[7:0];
        CFG_NOISE_RIGHT:   rr_q   <= cfg_data_i[7:0];
        CFG_NOISE_CROSS:   rc_q   <= signed'(cfg_data_i[8:0]);
        CFG_DRIVE_DIV:     ddiv_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign div_eff = (ddiv_q == 8'd0) ? 8'd1 : ddiv_q;
  assign drive_diff = 17'(item_q.drive_right) - 17'(item_q.drive_left);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_PMUL: begin
        mul_a = MUL_A_W'(x_q);
        mul_b = signed'({10'd0, div_eff});
      end
      OP_C1: begin
        mul_a = signed'({34'd0, rl_q});
        mul_b = signed'({10'd0, rr_q});
      end
      OP_C2: begin
        mul_a = MUL_A_W'(rc_q);
        mul_b = MUL_B_W'(rc_q);
      end
      OP_DET: begin
        mul_a = MUL_A_W'(p_q);
        mul_b = MUL_B_W'(f_q);
      end
      OP_K1: begin
        mul_a = MUL_A_W'(p_q);
        mul_b = MUL_B_W'(g1_q);
      end
      OP_K2: begin
        mul_a = MUL_A_W'(p_q);
        mul_b = MUL_B_W'(g2_q);
      end
      OP_N1: begin
        mul_a = k1_q;
        mul_b = MUL_B_W'(y1_q);
      end
      OP_N2: begin
        mul_a = k2_q;
        mul_b = MUL_B_W'(y2_q);
      end
      OP_PC: begin
        mul_a = MUL_A_W'(p_q);
        mul_b = MUL_B_W'(c_q);
      end
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_t = prod[DIV_W-1:0];

  // slopes and innovations from the predicted position
  always_comb begin
    t1   = 34'(x_q) + signed'({24'd0, soff_q});
    t2   = 34'(x_q) - signed'({24'd0, soff_q});
    pv1  = prof_val(t1, shw_q);
    pv2  = prof_val(t2, shw_q);
    hs1  = prof_slope(t1, shw_q);
    hs2  = prof_slope(t2, shw_q);
    f_c  = ((hs2 != 2'sd0) ? signed'({4'd0, rl_q}) : 12'sd0)
         + ((hs1 != 2'sd0) ? signed'({4'd0, rr_q}) : 12'sd0)
         - 12'(sel_sign(2'(hs1 * hs2), 11'(rc_q) <<< 1));
    g1_c = sel_sign(hs1, signed'({3'd0, rr_q})) - sel_sign(hs2, 11'(rc_q));
    g2_c = sel_sign(hs2, signed'({3'd0, rl_q})) - sel_sign(hs1, 11'(rc_q));
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = acc_q;
    div_den   = det_q;
    case (cmd_i.op)
      OP_PDIV: begin
        div_start = 1'b1;
        div_den   = signed'({{(DIV_W-8){1'b0}}, div_eff});
      end
      OP_XDIV: div_start = 1'b1;
      OP_CDIV: div_start = 1'b1;
      default: ;
    endcase
  end

  lpkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // variance correction: p - trunc(p - p*c/det)
  always_comb begin
    r_pos   = !div_rem[DIV_W-1] && (div_rem != '0);
    det_pos = !det_q[DIV_W-1] && (det_q != '0);
    dq      = (DIV_W+1)'(p_q) - (DIV_W+1)'(div_quot);
    if (div_rem != '0) begin
      if ((r_pos == det_pos) && (dq > 0))       dq = dq - 2'sd1;
      else if ((r_pos != det_pos) && (dq < 0))  dq = dq + 2'sd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      p_q <= signed'({11'd0, RST_INIT_VAR});
    end else begin
      case (cmd_i.op)
        OP_INIT: begin
          x_q <= '0;
          p_q <= signed'({11'd0, ivar_q});
        end
        OP_PFIN: begin
          x_q <= div_quot[31:0];
          p_q <= p_q + signed'({16'd0, pn_q});
        end
        OP_XFIN: x_q <= x_q + div_quot[31:0];
        OP_CFIN: p_q <= p_q - dq[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        item_q <= in_word_i;
        skip_q <= 1'b0;
      end
      OP_INIT: skip_q <= 1'b0;
      OP_PMUL: acc_q <= prod_t + DIV_W'(drive_diff);
      OP_SLOPE: begin
        y1_q <= signed'({2'd0, item_q.light_left}) - signed'({2'd0, pv1});
        y2_q <= signed'({2'd0, item_q.light_right}) - signed'({2'd0, pv2});
        f_q  <= f_c;
        g1_q <= g1_c;
        g2_q <= g2_c;
      end
      OP_C1:   acc_q <= prod_t;
      OP_C2:   c_q   <= 18'(acc_q - prod_t);
      OP_DET:  det_q <= prod_t + DIV_W'(c_q);
      OP_SKIP: skip_q <= 1'b1;
      OP_K1:   k1_q  <= prod[MUL_A_W-1:0];
      OP_K2:   k2_q  <= prod[MUL_A_W-1:0];
      OP_N1:   acc_q <= prod_t;
      OP_N2:   acc_q <= acc_q + prod_t;
      OP_PC:   acc_q <= prod_t;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_q.position_out   <= x_q;
      out_q.variance_out   <= p_q;
      out_q.update_skipped <= skip_q;
    end
  end

  assign sts_o.req_init = item_q.req_type;
  assign sts_o.det_zero = (det_q == '0);
  assign sts_o.div_done = div_done;
  assign out_word_o     = out_q;

endmodule

// File: hdl/lpkf_ctrl.sv
// Controller: sequences one filter word through the datapath
`timescale 1ns / 1ps
`include "line_position_kalman_filter_unit_macros.svh"
module lpkf_ctrl
  import lpkf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.req_init) begin
          cmd_o.op = OP_INIT;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = OP_PMUL;
          state_d  = ST_PDIV;
        end
      end
      ST_PDIV: begin
        cmd_o.op = OP_PDIV;
        state_d  = ST_PWAIT;
      end
      ST_PWAIT: if (sts_i.div_done) state_d = ST_PFIN;
      ST_PFIN: begin
        cmd_o.op = OP_PFIN;
        state_d  = ST_SLOPE;
      end
      ST_SLOPE: begin
        cmd_o.op = OP_SLOPE;
        state_d  = ST_C1;
      end
      ST_C1: begin
        cmd_o.op = OP_C1;
        state_d  = ST_C2;
      end
      ST_C2: begin
        cmd_o.op = OP_C2;
        state_d  = ST_DET;
      end
      ST_DET: begin
        cmd_o.op = OP_DET;
        state_d  = ST_K1;
      end
      ST_K1: begin
        if (sts_i.det_zero) begin
          cmd_o.op = OP_SKIP;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = OP_K1;
          state_d  = ST_K2;
        end
      end
      ST_K2: begin
        cmd_o.op = OP_K2;
        state_d  = ST_N1;
      end
      ST_N1: begin
        cmd_o.op = OP_N1;
        state_d  = ST_N2;
      end
      ST_N2: begin
        cmd_o.op = OP_N2;
        state_d  = ST_XDIV;
      end
      ST_XDIV: begin
        cmd_o.op = OP_XDIV;
        state_d  = ST_XWAIT;
      end
      ST_XWAIT: if (sts_i.div_done) state_d = ST_XFIN;
      ST_XFIN: begin
        cmd_o.op = OP_XFIN;
        state_d  = ST_PC;
      end
      ST_PC: begin
        cmd_o.op = OP_PC;
        state_d  = ST_CDIV;
      end
      ST_CDIV: begin
        cmd_o.op = OP_CDIV;
        state_d  = ST_CWAIT;
      end
      ST_CWAIT: if (sts_i.div_done) state_d = ST_CFIN;
      ST_CFIN: begin
        cmd_o.op = OP_CFIN;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  `LPKF_ASSERT_NXT(a_accept_leaves_idle, state_q == ST_IDLE && in_valid_i,
                   state_q == ST_DISPATCH, "accepted word did not start")
  `LPKF_ASSERT_IMP(a_div_done_waiting, sts_i.div_done,
                   state_q == ST_PWAIT || state_q == ST_XWAIT || state_q == ST_CWAIT,
                   "divider finished outside a wait state")
  `LPKF_ASSERT_IMP(a_no_overwrite, cmd_o.out_load, !out_valid_q || out_ready_i,
                   "result register overwritten while held")
  `LPKF_ASSERT_NXT(a_load_shows, cmd_o.out_load, out_valid_q && state_q == ST_IDLE,
                   "loaded result not presented")

endmodule

// File: hdl/line_position_kalman_filter_unit.sv
// Top level of the line position filter: controller, datapath and ports
// Usage:
//   Input channel in_valid_i/in_ready_o carries one word per request: init
//   (reset position to 0, variance to initial_variance) or filter step with
//   two light readings and two wheel drive commands.
//   Output channel out_valid_o/out_ready_i returns one word per request:
//   position, variance and the skipped-update flag.
//   Config channel cfg_valid_i/cfg_ready_o writes register cfg_index_i with
//   cfg_data_i; always ready, write only while idle.
//   An init word only resets the filter state; a step makes three passes
//   through the shared bit-serial divider (each: start, 49 quotient bits,
//   done) plus the multiply sequence.  Without the update (zero
//   determinant) a step makes only the first divider pass.
//   One word is in work at a time; the input is ready again in the cycle
//   after the result is loaded.
//   A stalled receiver holds the result; a finished word then waits for it.
//   Reset: all configuration registers return to their defaults, position
//   clears and variance loads the default initial variance.
`timescale 1ns / 1ps
module line_position_kalman_filter_unit
  import lpkf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lpkf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lpkf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_word_o)
  );

endmodule

// File: tb/sv/lpkf_checker.sv
// Checker for the line position filter: predicts each result word and compares it
`timescale 1ns / 1ps
module lpkf_checker
  import lpkf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_word_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          skipped_o
);

  longint sensor_offset, half_width, init_var, proc_noise;
  longint noise_l, noise_r, noise_c, drive_div;
  longint est_pos, est_var;
  out_word_t expected_q[$];

  function automatic longint wrap32(input longint v);
    logic [31:0] u;
    u = v[31:0];
    return longint'($signed(u));
  endfunction

  function automatic longint brightness(input longint t);
    if (t < -half_width) return 0;
    if (t < 0) return 255 + t;
    if (t <= half_width) return 255 - t;
    return 0;
  endfunction

  function automatic longint slope(input longint t);
    if (t < -half_width) return 0;
    if (t < 0) return 1;
    if (t <= half_width) return -1;
    return 0;
  endfunction

  function automatic out_word_t track_line(input in_word_t w);
    out_word_t r;
    longint ll, lr, dl, dr, dv, x, p, y1, y2, h1, h2, f, c, det;
    longint k1, k2, pc, q, rm, dq;
    logic frac_neg;
    r.update_skipped = 1'b0;
    if (w.req_type) begin
      est_pos = 0;
      est_var = init_var;
    end else begin
      ll = longint'(w.light_left);
      lr = longint'(w.light_right);
      dl = longint'($signed(w.drive_left));
      dr = longint'($signed(w.drive_right));
      dv = (drive_div != 0) ? drive_div : 1;
      x = wrap32((dv * est_pos + (dr - dl)) / dv);
      p = wrap32(est_var + proc_noise);
      y1 = ll - brightness(x + sensor_offset);
      y2 = lr - brightness(x - sensor_offset);
      h1 = slope(x + sensor_offset);
      h2 = slope(x - sensor_offset);
      f = noise_l * h2 * h2 + noise_r * h1 * h1 - 2 * h1 * h2 * noise_c;
      c = noise_l * noise_r - noise_c * noise_c;
      det = p * f + c;
      if (det == 0) begin
        r.update_skipped = 1'b1;
      end else begin
        k1 = p * (h1 * noise_r - h2 * noise_c);
        k2 = p * (h2 * noise_l - h1 * noise_c);
        x = wrap32(x + (k1 * y1 + k2 * y2) / det);
        pc = p * c;
        q = pc / det;
        rm = pc % det;
        dq = p - q;
        if (rm != 0) begin
          frac_neg = ((rm > 0) == (det > 0));
          if (frac_neg && dq > 0) dq = dq - 1;
          else if (!frac_neg && dq < 0) dq = dq + 1;
        end
        p = wrap32(p - dq);
      end
      est_pos = x;
      est_var = p;
    end
    r.position_out = est_pos[31:0];
    r.variance_out = est_var[31:0];
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      sensor_offset = 100;
      half_width = 200;
      init_var = 10000;
      proc_noise = 100;
      noise_l = 5;
      noise_r = 5;
      noise_c = 0;
      drive_div = 10;
      est_pos = 0;
      est_var = 10000;
      expected_q.delete();
      fail_count_o = 0;
      checked_o = 0;
      skipped_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SENSOR_OFFSET: sensor_offset = longint'(cfg_data_i[9:0]);
          CFG_HALF_WIDTH:    half_width = longint'(cfg_data_i[7:0]);
          CFG_INIT_VAR:      init_var = longint'(cfg_data_i[20:0]);
          CFG_PROC_NOISE:    proc_noise = longint'(cfg_data_i[15:0]);
          CFG_NOISE_LEFT:    noise_l = longint'(cfg_data_i[7:0]);
          CFG_NOISE_RIGHT:   noise_r = longint'(cfg_data_i[7:0]);
          CFG_NOISE_CROSS:   noise_c = longint'($signed(cfg_data_i[8:0]));
          CFG_DRIVE_DIV:     drive_div = longint'(cfg_data_i[7:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result word pos=%0d var=%0d skip=%0b", $realtime,
                     out_word_i.position_out, out_word_i.variance_out,
                     out_word_i.update_skipped);
        end else begin
          e = expected_q.pop_front();
          checked_o++;
          if (e.update_skipped) skipped_o++;
          if (out_word_i !== e) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch exp pos=%0d var=%0d skip=%0b got pos=%0d var=%0d skip=%0b",
                       $realtime, e.position_out, e.variance_out, e.update_skipped,
                       out_word_i.position_out, out_word_i.variance_out,
                       out_word_i.update_skipped);
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(track_line(in_word_i));
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top: drives the line position filter and reports the verdict
`timescale 1ns / 1ps
module tb;
  import lpkf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending, checked, skipped;
  int          gap_pct = 0;
  int          stall_pct = 0;
  longint      cycles = 0;
  int          sent = 0;

  line_position_kalman_filter_unit uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  lpkf_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_word_i(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .skipped_o(skipped)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(input in_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input int so, hw, iv, pn, nl, nr, nc, dd);
    write_reg(CFG_SENSOR_OFFSET, so);
    write_reg(CFG_HALF_WIDTH, hw);
    write_reg(CFG_INIT_VAR, iv);
    write_reg(CFG_PROC_NOISE, pn);
    write_reg(CFG_NOISE_LEFT, nl);
    write_reg(CFG_NOISE_RIGHT, nr);
    write_reg(CFG_NOISE_CROSS, nc);
    write_reg(CFG_DRIVE_DIV, dd);
  endtask

  function automatic in_word_t make_word(input logic init, input int ll, lr, dl, dr);
    in_word_t w;
    w.req_type = init;
    w.light_left = ll[7:0];
    w.light_right = lr[7:0];
    w.drive_left = dl[15:0];
    w.drive_right = dr[15:0];
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int ds;
    w = make_word($urandom_range(99) < 8, 0, 0, 0, 0);
    w.light_left = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                               : $urandom_range(255, 150));
    w.light_right = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                : $urandom_range(255, 150));
    if ($urandom_range(99) < 70) begin
      ds = $urandom_range(200) - 100;
      w.drive_left = 16'($urandom_range(65535));
      w.drive_right = w.drive_left + ds[15:0];
    end else begin
      w.drive_left = 16'($urandom_range(65535));
      w.drive_right = 16'($urandom_range(65535));
    end
    return w;
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults, then field extremes
    send_word(make_word(1, 0, 0, 0, 0));
    send_word(make_word(0, 255, 255, 0, 0));
    send_word(make_word(0, 0, 0, 0, 0));
    send_word(make_word(0, 255, 0, -32768, 32767));
    send_word(make_word(0, 0, 255, 32767, -32768));
    send_word(make_word(0, 200, 200, 5, -5));
    send_word(make_word(0, 128, 64, -32768, -32768));
    send_word(make_word(1, 255, 255, -1, -1));
    settle();

    // all noise zero: determinant vanishes, update skipped
    load_regs(100, 200, 10000, 100, 0, 0, 0, 10);
    send_word(make_word(0, 200, 100, 0, 30));
    send_word(make_word(0, 50, 255, 10, 0));
    settle();

    // large settings, divisor zero treated as one
    load_regs(1023, 255, 1048576, 65535, 255, 255, 255, 0);
    send_word(make_word(1, 0, 0, 0, 0));
    send_word(make_word(0, 255, 255, 32767, -32768));
    send_word(make_word(0, 0, 255, 0, 0));
    settle();
    load_regs(0, 0, 0, 0, 255, 255, -255, 255);
    send_word(make_word(1, 0, 0, 0, 0));
    send_word(make_word(0, 255, 0, 0, 1));
    send_word(make_word(0, 10, 240, -32768, 32767));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 56; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 56; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      load_regs($urandom_range(300), $urandom_range(255), $urandom_range(1048576),
                $urandom_range(65535), $urandom_range(255), $urandom_range(255),
                int'($urandom_range(510)) - 255, $urandom_range(255, 1));
      send_word(make_word(1, 0, 0, 0, 0));
      for (int i = 0; i < 120; i++) send_word(rand_word());
      settle();
    end

    $display("run covered %0d words (%0d checked, %0d with skipped update)", sent, checked,
             skipped);
    $display("over default, extreme and random register settings with four idling mixes");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lpkf_pkg.sv
hdl/lpkf_div.sv
hdl/lpkf_datapath.sv
hdl/lpkf_ctrl.sv
hdl/line_position_kalman_filter_unit.sv
tb/sv/lpkf_checker.sv
tb/sv/tb.sv
